@@ hw/rtl/bchh_pkg.sv @@
// Package for the bunch crossing hit histogrammer.
// Holds sizes, register indexes, beat structs and the crossing lookup table.
// No dependencies; the top level refers to it by scoped names.
package bchh_pkg;

  localparam int NUM_CROSSINGS = 120;
  localparam int ADC_BITS      = 16;
  localparam int COUNT_BITS    = 32;

  localparam int CROSS_W   = (NUM_CROSSINGS > 1) ? $clog2(NUM_CROSSINGS) : 1;
  localparam int ROW_W     = CROSS_W + 1;
  localparam int ROWS      = 2 << CROSS_W;
  localparam int ROW_BITS  = 4 * COUNT_BITS;
  localparam int SUM_W     = 8;
  localparam int LUT_DEPTH = 1 << SUM_W;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_CROSSING_SHIFT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SUM1_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUM2_THRESHOLD  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VETO_THRESHOLD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIP_THRESHOLD = 3'd4;

  localparam logic KIND_EVENT   = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        side;
    logic [6:0]  bunch;
    logic [15:0] sum1;
    logic [15:0] sum2;
    logic [15:0] veto_front;
    logic [15:0] veto_back;
    logic        shower_ok;
    logic [63:0] horiz_strips;
    logic [63:0] vert_strips;
  } in_beat_t;

  typedef struct packed {
    logic [6:0]  crossing;
    logic [3:0]  fill_mask;
    logic [31:0] count_left;
    logic [31:0] count_right;
    logic [31:0] count_down;
    logic [31:0] count_up;
  } out_beat_t;

  typedef logic [LUT_DEPTH-1:0][CROSS_W-1:0] cross_lut_t;

  // Table of v mod NUM_CROSSINGS for every possible 8-bit sum.
  function automatic cross_lut_t cross_lut();
    cross_lut_t t;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      t[i] = CROSS_W'(i % NUM_CROSSINGS);
    end
    return t;
  endfunction

endpackage

@@ hw/rtl/bunch_crossing_hit_histogrammer.sv @@
// Top level of the bunch crossing hit histogrammer.
// Depends on bchh_pkg (sizes, beat types, lookup table) and bchh_ram (count store).
//
// Usage:
// An input beat on item is accepted at a rising edge where start is high and
// busy is low. busy is always low: the block takes one beat every cycle.
// An event beat (kind 0) picks its crossing as (bunch + crossing_shift) modulo
// the crossing count, applies the sum, veto and shower cuts and, if they pass,
// bumps each of the four saturating counters of its side and crossing whose
// strip pair is above the strip threshold. A readout beat (kind 1) reads the
// four counters of crossing bunch modulo the crossing count, unchanged.
// Every accepted beat gives exactly one result beat on result, marked by done
// for one cycle, after the update stage and result registers. The receiver cannot
// stall, so results are never held back and nothing queues up.
// The counters live in one RAM row per side and crossing (four counters per
// row). The registered RAM read returns in the update stage; a read-modify-write
// of one row per cycle sets the rate of one beat per cycle.
// A write-data bypass covers back-to-back beats on the same row.
// Reset (synchronous, active high) restores the register defaults and clears
// one valid flop per row; a row that is not valid reads as all-zero counts,
// so no clearing pass is needed and the block is ready the cycle after reset.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
module bunch_crossing_hit_histogrammer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  bchh_pkg::in_beat_t                   item,
  output logic                                 done,
  output bchh_pkg::out_beat_t                  result,
  input  logic                                 cfg_we,
  input  logic [bchh_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bchh_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CB = bchh_pkg::COUNT_BITS;
  localparam int AB = bchh_pkg::ADC_BITS;
  localparam bchh_pkg::cross_lut_t CROSS_LUT = bchh_pkg::cross_lut();
  localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

  // Configuration registers.
  logic [6:0]  crossing_shift;
  logic [15:0] sum1_threshold;
  logic [15:0] sum2_threshold;
  logic [15:0] veto_threshold;
  logic [15:0] strip_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_shift  <= 7'd0;
      sum1_threshold  <= 16'd100;
      sum2_threshold  <= 16'd15;
      veto_threshold  <= 16'd150;
      strip_threshold <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bchh_pkg::REG_CROSSING_SHIFT:  crossing_shift  <= cfg_data[6:0];
        bchh_pkg::REG_SUM1_THRESHOLD:  sum1_threshold  <= cfg_data;
        bchh_pkg::REG_SUM2_THRESHOLD:  sum2_threshold  <= cfg_data;
        bchh_pkg::REG_VETO_THRESHOLD:  veto_threshold  <= cfg_data;
        bchh_pkg::REG_STRIP_THRESHOLD: strip_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Accept stage: crossing lookup, cuts and strip pairs, RAM read issue.
  logic                              accept;
  logic [bchh_pkg::SUM_W-1:0]        cross_sum;
  logic [bchh_pkg::CROSS_W-1:0]      cross_in;
  logic                              cuts_pass;
  logic [3:0]                        pair_hits;
  logic [3:0]                        mask_in;
  logic [bchh_pkg::ROW_W-1:0]        row_in;

  function automatic logic pair_above(input logic [31:0] pair, input logic [AB-1:0] th);
    return (pair[AB-1:0] > th) && (pair[16 +: AB] > th);
  endfunction

  assign accept = start && !busy;

  always_comb begin
    if (item.kind == bchh_pkg::KIND_READOUT) begin
      cross_sum = {1'b0, item.bunch};
    end else begin
      cross_sum = {1'b0, item.bunch} + {1'b0, crossing_shift};
    end
    cross_in = CROSS_LUT[cross_sum];
    row_in   = {item.side, cross_in};

    cuts_pass = (item.sum1[AB-1:0] > sum1_threshold[AB-1:0])
             && (item.sum2[AB-1:0] > sum2_threshold[AB-1:0])
             && (item.veto_front[AB-1:0] < veto_threshold[AB-1:0])
             && (item.veto_back[AB-1:0] < veto_threshold[AB-1:0])
             && item.shower_ok;

    pair_hits[0] = pair_above(item.horiz_strips[31:0],  strip_threshold[AB-1:0]);
    pair_hits[1] = pair_above(item.horiz_strips[63:32], strip_threshold[AB-1:0]);
    pair_hits[2] = pair_above(item.vert_strips[31:0],   strip_threshold[AB-1:0]);
    pair_hits[3] = pair_above(item.vert_strips[63:32],  strip_threshold[AB-1:0]);

    if (item.kind == bchh_pkg::KIND_EVENT && cuts_pass) begin
      mask_in = pair_hits;
    end else begin
      mask_in = 4'd0;
    end
  end

  // Update stage registers.
  logic                              s1_valid;
  logic [bchh_pkg::ROW_W-1:0]        s1_row;
  logic [bchh_pkg::CROSS_W-1:0]      s1_cross;
  logic [3:0]                        s1_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_row   <= row_in;
    s1_cross <= cross_in;
    s1_mask  <= mask_in;
  end

  // Count store and per-row valid flops.
  logic                              ram_we;
  logic [bchh_pkg::ROW_BITS-1:0]     ram_rdata;
  logic [bchh_pkg::ROW_BITS-1:0]     row_new;
  logic [bchh_pkg::ROWS-1:0]         row_valid;

  bchh_ram #(
    .WIDTH (bchh_pkg::ROW_BITS),
    .DEPTH (bchh_pkg::ROWS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_row),
    .wdata (row_new),
    .raddr (row_in),
    .rdata (ram_rdata)
  );

  // Bypass holds the most recent row write; the RAM read that was issued on
  // the same edge as that write returns the old contents.
  logic                              byp_valid;
  logic [bchh_pkg::ROW_W-1:0]        byp_row;
  logic [bchh_pkg::ROW_BITS-1:0]     byp_data;
  logic [bchh_pkg::ROW_BITS-1:0]     row_cur;

  always_comb begin
    if (!row_valid[s1_row]) begin
      row_cur = '0;
    end else if (byp_valid && byp_row == s1_row) begin
      row_cur = byp_data;
    end else begin
      row_cur = ram_rdata;
    end

    for (int k = 0; k < 4; k++) begin
      if (s1_mask[k] && row_cur[k*CB +: CB] != COUNT_MAX) begin
        row_new[k*CB +: CB] = row_cur[k*CB +: CB] + CB'(1);
      end else begin
        row_new[k*CB +: CB] = row_cur[k*CB +: CB];
      end
    end

    ram_we = s1_valid && (s1_mask != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      byp_valid <= 1'b0;
    end else if (ram_we) begin
      row_valid[s1_row] <= 1'b1;
      byp_valid         <= 1'b1;
    end
    if (ram_we) begin
      byp_row  <= s1_row;
      byp_data <= row_new;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    result.crossing    <= 7'(s1_cross);
    result.fill_mask   <= s1_mask;
    result.count_left  <= 32'(row_new[0*CB +: CB]);
    result.count_right <= 32'(row_new[1*CB +: CB]);
    result.count_down  <= 32'(row_new[2*CB +: CB]);
    result.count_up    <= 32'(row_new[3*CB +: CB]);
  end

  // Every accepted beat reaches the update stage, and each one yields a result.
  a_accept_to_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat did not reach the update stage");

  a_update_to_done: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("update stage produced no result beat");

  // A filled left counter can never read back as zero.
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && result.fill_mask[0] |-> result.count_left != 32'd0)
    else $error("left counter zero after a fill");

  // The bypass always describes a row that has been written.
  a_bypass_row_valid: assert property (@(posedge clk) disable iff (rst)
    byp_valid |-> row_valid[byp_row])
    else $error("bypass holds a row with a clear valid flag");

endmodule

@@ hw/rtl/bchh_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no package dependencies.
module bchh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ bench/bunch_crossing_hit_histogrammer_tb.sv @@
// Self-checking testbench for the bunch crossing hit histogrammer.
// Needs bchh_pkg, the top level bunch_crossing_hit_histogrammer and bchh_ram; the
// scoreboard runs its own copy of the counter banks.
module bunch_crossing_hit_histogrammer_tb;
  import bchh_pkg::*;

  // Register indexes past the last real register. The block must ignore writes to them.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  // Strip values one above and exactly at the reset strip threshold of 100.
  localparam logic [15:0] STRIP_HIT  = 16'd101;
  localparam logic [15:0] STRIP_MISS = 16'd100;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic                   busy;
  in_beat_t               item      = '0;
  logic                   done;
  out_beat_t              result;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  bunch_crossing_hit_histogrammer dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // The scoreboard keeps its own copy of the registers. The reset values
  // match the block's defaults.
  logic [6:0]  shift_cfg = 7'd0;
  logic [15:0] sum1_cfg  = 16'd100;
  logic [15:0] sum2_cfg  = 16'd15;
  logic [15:0] veto_cfg  = 16'd150;
  logic [15:0] strip_cfg = 16'd100;

  // The scoreboard also keeps its own counter banks, indexed by side, crossing,
  // and counter (left, right, down, up).
  logic [COUNT_BITS-1:0] tally [2][NUM_CROSSINGS][4];

  in_beat_t    queued_beats[$];     // Beats that the driver has not yet presented.
  out_beat_t   awaited_tallies[$];  // Expected result beats, oldest first.
  int unsigned mismatches = 0;
  int unsigned idle_left  = 0;
  bit          steady_flow = 1'b1;  // When set, the sender offers a beat on every cycle.
  logic [6:0]  hot_bunch   = 7'd0;  // Bunch number that is reused often within a phase.

  // Append one beat at the tail of the pending queue.
  function automatic void queue_beat(in_beat_t b);
    queued_beats.insert(queued_beats.size(), b);
  endfunction

  // Both strips of the pair that starts at slot lo must be strictly above the
  // strip threshold.
  function automatic bit pair_over(logic [63:0] strips, int lo);
    return strips[16*lo +: 16] > strip_cfg && strips[16*(lo+1) +: 16] > strip_cfg;
  endfunction

  // Work out the result beat that one accepted beat produces, and update the
  // scoreboard's counter banks in the same step.
  function automatic out_beat_t tally_beat(in_beat_t b);
    out_beat_t   r;
    int unsigned x;
    int unsigned s;
    logic [3:0]  mask;
    mask = 4'd0;
    s = int'(b.side);
    if (b.kind == KIND_READOUT) begin
      x = int'(b.bunch) % NUM_CROSSINGS;
    end else begin
      // The shift register may hold up to 127, and the sum still wraps by
      // the crossing count.
      x = (int'(b.bunch) + int'(shift_cfg)) % NUM_CROSSINGS;
      if (b.sum1 > sum1_cfg && b.sum2 > sum2_cfg && b.veto_front < veto_cfg &&
          b.veto_back < veto_cfg && b.shower_ok == 1'b1) begin
        mask[0] = pair_over(b.horiz_strips, 0);
        mask[1] = pair_over(b.horiz_strips, 2);
        mask[2] = pair_over(b.vert_strips, 0);
        mask[3] = pair_over(b.vert_strips, 2);
        // A full counter keeps its value, but its mask bit is still set.
        for (int k = 0; k < 4; k++) begin
          if (mask[k] && tally[s][x][k] != '1) tally[s][x][k]++;
        end
      end
    end
    r.crossing    = 7'(x);
    r.fill_mask   = mask;
    r.count_left  = tally[s][x][0];
    r.count_right = tally[s][x][1];
    r.count_down  = tally[s][x][2];
    r.count_up    = tally[s][x][3];
    return r;
  endfunction

  // Return an ADC value close to a threshold. When above is set the value is
  // biased to sit above the threshold, otherwise below it. The value sometimes
  // lands exactly on the threshold, and sometimes anywhere in the full range,
  // so that every bit takes both values.
  function automatic logic [15:0] adc_near(logic [15:0] thr, bit above);
    int unsigned r;
    int          room;
    r = $urandom_range(0, 9);
    if (r == 0) return thr;
    if (r == 1) return 16'($urandom());
    if (above) begin
      room = 65535 - int'(thr);
      if (room == 0) return thr;
      return thr + 16'($urandom_range(1, (room < 200) ? room : 200));
    end
    room = int'(thr);
    if (room == 0) return thr;
    return thr - 16'($urandom_range(1, (room < 200) ? room : 200));
  endfunction

  function automatic in_beat_t event_beat(logic side, logic [6:0] bunch, logic [15:0] s1,
                                          logic [15:0] s2, logic [15:0] vf, logic [15:0] vb,
                                          logic shower, logic [63:0] h, logic [63:0] v);
    in_beat_t b;
    b.kind         = KIND_EVENT;
    b.side         = side;
    b.bunch        = bunch;
    b.sum1         = s1;
    b.sum2         = s2;
    b.veto_front   = vf;
    b.veto_back    = vb;
    b.shower_ok    = shower;
    b.horiz_strips = h;
    b.vert_strips  = v;
    return b;
  endfunction

  // A readout beat carries random data in every field that it does not use.
  function automatic in_beat_t readout_beat(logic side, logic [6:0] bunch);
    return '{kind: KIND_READOUT, side: side, bunch: bunch,
             sum1: 16'($urandom()), sum2: 16'($urandom()),
             veto_front: 16'($urandom()), veto_back: 16'($urandom()),
             shower_ok: 1'($urandom()), horiz_strips: {$urandom(), $urandom()},
             vert_strips: {$urandom(), $urandom()}};
  endfunction

  // Most random beats are events that are biased to pass the cuts, so that
  // the counters actually climb. The others are events with random fields and
  // readouts. Two in five bunch numbers are the hot bunch, whose two rows are hit
  // again and again to exercise the bypass for back-to-back beats on the same row.
  function automatic in_beat_t random_beat();
    in_beat_t b;
    bit       bias;
    bias = ($urandom_range(0, 99) < 75);
    if ($urandom_range(0, 99) < 20) begin
      return readout_beat(1'($urandom()), ($urandom_range(0, 99) < 40) ? hot_bunch
                                                                       : 7'($urandom()));
    end
    b = '0;
    b.kind       = KIND_EVENT;
    b.side       = 1'($urandom());
    b.bunch      = ($urandom_range(0, 99) < 40) ? hot_bunch : 7'($urandom());
    b.sum1       = adc_near(sum1_cfg, bias || $urandom_range(0, 1) == 1);
    b.sum2       = adc_near(sum2_cfg, bias || $urandom_range(0, 1) == 1);
    b.veto_front = adc_near(veto_cfg, !(bias || $urandom_range(0, 1) == 1));
    b.veto_back  = adc_near(veto_cfg, !(bias || $urandom_range(0, 1) == 1));
    b.shower_ok  = bias ? ($urandom_range(0, 9) != 0) : 1'($urandom());
    for (int i = 0; i < 4; i++) begin
      b.horiz_strips[16*i +: 16] = adc_near(strip_cfg, $urandom_range(0, 99) < 75);
      b.vert_strips[16*i +: 16]  = adc_near(strip_cfg, $urandom_range(0, 99) < 75);
    end
    return b;
  endfunction

  // Most gaps between beats are short and a few are long. While steady_flow is
  // set there are no gaps at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver. A beat is accepted at an edge where start is high and busy is low.
  // At that edge the beat is scored, and the next one is either presented at
  // once, so that start stays high, or held back for a gap. A stalled beat
  // stays on the port unchanged.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (!(start && busy)) begin
      if (start) awaited_tallies.insert(awaited_tallies.size(), tally_beat(item));
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (queued_beats.size() > 0) begin
        item  <= queued_beats.pop_front();
        start <= 1'b1;
        idle_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor. Each result beat is up for one cycle only and cannot be held off.
  // It is compared with the oldest expected result.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && done === 1'b1) begin
      if (awaited_tallies.size() == 0) begin
        $error("result beat with no expectation waiting: crossing %0d", result.crossing);
        mismatches++;
      end else begin
        want = awaited_tallies.pop_front();
        check_field("crossing", 32'(want.crossing), 32'(result.crossing));
        check_field("fill_mask", 32'(want.fill_mask), 32'(result.fill_mask));
        check_field("count_left", want.count_left, result.count_left);
        check_field("count_right", want.count_right, result.count_right);
        check_field("count_down", want.count_down, result.count_down);
        check_field("count_up", want.count_up, result.count_up);
      end
    end
  end

  // Wait until every queued beat has been accepted and every result has come
  // back, then let the pipeline drain fully. The check is made at the falling edge,
  // where no update is pending.
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_beats.size() != 0 || start || awaited_tallies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes that follow each other keep cfg_we high, and end_writes lowers it after
  // the last write.
  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_CROSSING_SHIFT:  shift_cfg = data[6:0];
      REG_SUM1_THRESHOLD:  sum1_cfg  = data;
      REG_SUM2_THRESHOLD:  sum2_cfg  = data;
      REG_VETO_THRESHOLD:  veto_cfg  = data;
      REG_STRIP_THRESHOLD: strip_cfg = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One phase of random traffic. First the block is drained, so the sender
  // pauses until every expected result has come. Then all five registers are
  // reprogrammed, and optionally an unused index is written as well. Last, a
  // batch of random beats is queued with a new flow pattern and a new hot bunch.
  task automatic run_phase(input logic [15:0] shift, input logic [15:0] s1,
                           input logic [15:0] s2, input logic [15:0] veto,
                           input logic [15:0] strip, input int unsigned beats,
                           input bit poke_unused);
    wait_drained();
    set_reg(REG_CROSSING_SHIFT, shift);
    set_reg(REG_SUM1_THRESHOLD, s1);
    set_reg(REG_SUM2_THRESHOLD, s2);
    set_reg(REG_VETO_THRESHOLD, veto);
    set_reg(REG_STRIP_THRESHOLD, strip);
    if (poke_unused) set_reg(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), 16'($urandom()));
    end_writes();
    @(negedge clk);
    steady_flow = ($urandom_range(0, 3) == 0);
    hot_bunch   = 7'($urandom());
    repeat (beats) queue_beat(random_beat());
  endtask

  initial begin
    foreach (tally[s, c, k]) tally[s][c][k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats at the reset register values: sums must exceed 100 and
    // 15, vetoes must stay below 150, and strips must exceed 100. They run with
    // no gaps, so that the beats on the same row follow each other closely.
    steady_flow = 1'b1;
    queue_beat(readout_beat(1'b0, 7'd0));
    // A readout bunch above the last crossing wraps around.
    queue_beat(readout_beat(1'b1, 7'd127));
    // Two passing events on one row, then a readout of that row.
    queue_beat(event_beat(1'b0, 7'd5, 16'd101, 16'd16, 16'd149, 16'd149, 1'b1,
                          {4{STRIP_HIT}}, {4{STRIP_HIT}}));
    queue_beat(event_beat(1'b0, 7'd5, 16'd101, 16'd16, 16'd149, 16'd149, 1'b1,
                          {4{STRIP_HIT}}, {4{STRIP_HIT}}));
    queue_beat(readout_beat(1'b0, 7'd5));
    // Each cut fails on its own boundary, so every one of these is rejected.
    queue_beat(event_beat(1'b0, 7'd5, 16'd100, 16'd16, 16'd0, 16'd0, 1'b1,
                          {4{STRIP_HIT}}, {4{STRIP_HIT}}));
    queue_beat(event_beat(1'b0, 7'd5, 16'd101, 16'd15, 16'd0, 16'd0, 1'b1,
                          {4{STRIP_HIT}}, {4{STRIP_HIT}}));
    queue_beat(event_beat(1'b0, 7'd5, 16'd101, 16'd16, 16'd150, 16'd0, 1'b1,
                          {4{STRIP_HIT}}, {4{STRIP_HIT}}));
    queue_beat(event_beat(1'b0, 7'd5, 16'd101, 16'd16, 16'd0, 16'd150, 1'b1,
                          {4{STRIP_HIT}}, {4{STRIP_HIT}}));
    queue_beat(event_beat(1'b0, 7'd5, 16'd101, 16'd16, 16'd0, 16'd0, 1'b0,
                          {4{STRIP_HIT}}, {4{STRIP_HIT}}));
    // One strip pair at a time: left, then right, then down, then up. The
    // other pairs each have at least one strip sitting exactly on the threshold.
    queue_beat(event_beat(1'b1, 7'd9, 16'd101, 16'd16, 16'd0, 16'd0, 1'b1,
                          {STRIP_HIT, STRIP_MISS, STRIP_HIT, STRIP_HIT},
                          {4{STRIP_MISS}}));
    queue_beat(event_beat(1'b1, 7'd9, 16'd101, 16'd16, 16'd0, 16'd0, 1'b1,
                          {STRIP_HIT, STRIP_HIT, STRIP_HIT, STRIP_MISS},
                          {4{STRIP_MISS}}));
    queue_beat(event_beat(1'b1, 7'd9, 16'd101, 16'd16, 16'd0, 16'd0, 1'b1,
                          {4{STRIP_MISS}},
                          {STRIP_HIT, STRIP_MISS, STRIP_HIT, STRIP_HIT}));
    queue_beat(event_beat(1'b1, 7'd9, 16'd101, 16'd16, 16'd0, 16'd0, 1'b1,
                          {4{STRIP_MISS}},
                          {STRIP_HIT, STRIP_HIT, STRIP_HIT, STRIP_MISS}));
    // Field extremes: an event of all zeros, a beat of all ones (which is a
    // readout of bunch 127), and a passing event at the largest values.
    queue_beat('0);
    queue_beat('1);
    queue_beat(event_beat(1'b1, 7'd127, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1,
                          '1, '1));
    queue_beat(event_beat(1'b1, 7'd119, 16'd101, 16'd16, 16'd0, 16'd0, 1'b1,
                          '1, '1));
    queue_beat(readout_beat(1'b1, 7'd7));
    queue_beat(readout_beat(1'b1, 7'd119));
    queue_beat(readout_beat(1'b1, 7'd120));

    // Random phases. The settings include zero thresholds with the widest veto
    // window and a shift of 127, then all thresholds at their maximum, then a
    // zero veto threshold and a full random shift word. Those last two phases can
    // pass no event, so they are kept short.
    run_phase(16'($urandom_range(0, 119)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 500)), 16'($urandom_range(200, 4000)),
              16'($urandom_range(0, 2000)), 200, 1'b0);
    run_phase(16'd127, 16'd0, 16'd0, 16'hFFFF, 16'd0, 150, 1'b1);
    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 40, 1'b0);
    run_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'd0, 16'($urandom()),
              40, 1'b1);
    run_phase(16'($urandom_range(0, 119)), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 16'($urandom()), 150, 1'b0);
    run_phase(16'($urandom_range(0, 127)), 16'($urandom_range(0, 300)),
              16'($urandom_range(0, 300)), 16'($urandom_range(1000, 65535)),
              16'($urandom_range(0, 300)), 170, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog. A correct run needs well under a tenth of this time, even with
  // the longest gaps between beats.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
